>>> design/phl_pkg.sv
// Shared constants, operation codes and interface structs of the pad hit locator.
// No dependencies; every other file of the block but phl_div imports it.
package phl_pkg;

   localparam int PHL_MAX_SIDE = 64;

   localparam int COORD_W    = 24;
   localparam int TRIG_W     = 16;
   localparam int WIDTH_W    = 23;
   localparam int COUNT_W    = 7;
   localparam int POINT_W    = 31;
   localparam int PAD_W      = 12;
   localparam int NUM_PADS   = 4096;
   localparam int Q_SHIFT    = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [1:0] OP_LOCATE   = 2'd0;
   localparam logic [1:0] OP_ACTIVATE = 2'd1;
   localparam logic [1:0] OP_LOOKUP   = 2'd2;
   localparam logic [1:0] OP_CLEAR    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COS_ROT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIN_ROT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_Y  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COLUMNS  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS     = 3'd7;

   localparam logic [TRIG_W-1:0]  RST_COS_ROT = 16'd32767;
   localparam logic [WIDTH_W-1:0] RST_WIDTH   = 23'd25600;
   localparam logic [COUNT_W-1:0] RST_COUNT   = 7'd1;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [TRIG_W-1:0]  cos_rot;
      logic [TRIG_W-1:0]  sin_rot;
      logic [WIDTH_W-1:0] width_x;
      logic [WIDTH_W-1:0] width_y;
      logic [COUNT_W-1:0] columns;
      logic [COUNT_W-1:0] rows;
   } phl_cfg_type;

   typedef struct packed {
      logic               go;
      logic [1:0]         kind;
      logic [PAD_W-1:0]   addr;
      logic [POINT_W-1:0] point;
   } phl_store_cmd_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic               found;
      logic [POINT_W-1:0] point;
   } phl_store_stat_type;

   typedef struct packed {
      logic             done;
      logic             in_sector;
      logic [PAD_W-1:0] chan;
   } phl_geom_res_type;

endpackage

>>> design/phl_div.sv
// Restoring divider with a bounded quotient: one quotient bit per cycle, MSB first.
// Standalone; used by phl_geom for the column and row index.
module phl_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 23,
   parameter int Q_W   = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [Q_W-1:0]   quo
);

   localparam int CW = $clog2(Q_W);

   logic [NUM_W-1:0] rem_ff, rem_in, trial;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in, ge;

   assign trial = NUM_W'(den_ff) << cnt_ff;
   assign ge    = (rem_ff >= trial);

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num;
         den_in = den;
         q_in   = '0;
         cnt_in = CW'(Q_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - trial;
         end
         q_in = {q_ff[Q_W-2:0], ge};
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

>>> design/phl_geom.sv
// Hit geometry: centre offset, Q1.15 rotation on one shared multiplier, bounds check,
// column and row through phl_div, channel number. Depends on phl_pkg and phl_div.
module phl_geom import phl_pkg::*; #(
   parameter int MAX_SIDE = PHL_MAX_SIDE
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COORD_W-1:0] x_pos,
   input  logic [COORD_W-1:0] y_pos,
   input  phl_cfg_type        cfg,
   output phl_geom_res_type   res
);

   localparam int NW    = $clog2(MAX_SIDE + 1);
   localparam int NUM_W = WIDTH_W + NW;
   localparam int CHW   = 2 * NW + 1;
   localparam int SW    = (CHW > PAD_W) ? CHW : PAD_W;
   localparam int DW    = COORD_W + 1;
   localparam int PW    = DW + TRIG_W;
   localparam int AW    = PW + 1;
   localparam int XW    = AW - Q_SHIFT + 1;
   localparam int XMW   = XW - 1;

   localparam logic [2:0] G_IDLE  = 3'd0;
   localparam logic [2:0] G_MUL   = 3'd1;
   localparam logic [2:0] G_BOUND = 3'd2;
   localparam logic [2:0] G_CHECK = 3'd3;
   localparam logic [2:0] G_DIVX  = 3'd4;
   localparam logic [2:0] G_DIVY  = 3'd5;

   logic [2:0]              st_ff, st_in, step_ff, step_in;
   logic signed [DW-1:0]    dx_ff, dx_in, dy_ff, dy_in, mul_a;
   logic signed [TRIG_W-1:0] mul_b;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [AW-1:0]    xacc_ff, xacc_in, yacc_ff, yacc_in, prod_ext;
   logic signed [XW-1:0]    xi_ff, xi_in, yi_ff, yi_in;
   logic [WIDTH_W-1:0]      wx_e, wy_e, div_den, div_v;
   logic [NW-1:0]           nc_e, nr_e, col_ff, col_in, q_clamp, clamp_n, div_q, div_n;
   logic                    inside_ok, div_start, div_done;
   logic [NUM_W-1:0]        div_num;
   logic [SW-1:0]           chan_full;
   logic                    done_ff, done_in, inside_ff, inside_in;
   logic [PAD_W-1:0]        chan_ff, chan_in;

   assign wx_e = (cfg.width_x == '0) ? WIDTH_W'(1) : cfg.width_x;
   assign wy_e = (cfg.width_y == '0) ? WIDTH_W'(1) : cfg.width_y;

   always_comb begin
      if (cfg.columns == '0) begin
         nc_e = NW'(1);
      end else if (32'(cfg.columns) > 32'(MAX_SIDE)) begin
         nc_e = NW'(MAX_SIDE);
      end else begin
         nc_e = NW'(cfg.columns);
      end
      if (cfg.rows == '0) begin
         nr_e = NW'(1);
      end else if (32'(cfg.rows) > 32'(MAX_SIDE)) begin
         nr_e = NW'(MAX_SIDE);
      end else begin
         nr_e = NW'(cfg.rows);
      end
   end

   assign mul_a    = (step_ff == 3'd0 || step_ff == 3'd3) ? dx_ff : dy_ff;
   assign mul_b    = (step_ff == 3'd0 || step_ff == 3'd2) ? $signed(cfg.cos_rot)
                                                          : $signed(cfg.sin_rot);
   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {prod_ff[PW-1], prod_ff};

   assign xi_in = {xacc_ff[AW-1], xacc_ff[AW-1:Q_SHIFT]} + XW'(wx_e >> 1);
   assign yi_in = {yacc_ff[AW-1], yacc_ff[AW-1:Q_SHIFT]} + XW'(wy_e >> 1);

   assign inside_ok = !xi_ff[XW-1] && (xi_ff[XW-2:0] <= XMW'(wx_e))
                   && !yi_ff[XW-1] && (yi_ff[XW-2:0] <= XMW'(wy_e));

   assign div_v     = (st_ff == G_CHECK) ? xi_ff[WIDTH_W-1:0] : yi_ff[WIDTH_W-1:0];
   assign div_n     = (st_ff == G_CHECK) ? nc_e : nr_e;
   assign div_num   = NUM_W'(div_v) * NUM_W'(div_n);
   assign div_den   = (st_ff == G_CHECK) ? wx_e : wy_e;
   assign div_start = (st_ff == G_CHECK && inside_ok) || (st_ff == G_DIVX && div_done);

   assign clamp_n   = (st_ff == G_DIVX) ? nc_e : nr_e;
   assign q_clamp   = (div_q >= clamp_n) ? clamp_n - NW'(1) : div_q;
   assign chan_full = SW'(q_clamp) * SW'(nc_e) + SW'(col_ff);

   phl_div #(
      .NUM_W (NUM_W),
      .DEN_W (WIDTH_W),
      .Q_W   (NW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_q)
   );

   always_comb begin
      st_in     = st_ff;
      step_in   = step_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      xacc_in   = xacc_ff;
      yacc_in   = yacc_ff;
      col_in    = col_ff;
      done_in   = 1'b0;
      inside_in = inside_ff;
      chan_in   = chan_ff;
      case (st_ff)
         G_IDLE: begin
            if (start) begin
               dx_in   = {x_pos[COORD_W-1], x_pos} - {cfg.center_x[COORD_W-1], cfg.center_x};
               dy_in   = {y_pos[COORD_W-1], y_pos} - {cfg.center_y[COORD_W-1], cfg.center_y};
               step_in = 3'd0;
               st_in   = G_MUL;
            end
         end
         G_MUL: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1: xacc_in = prod_ext;
               3'd2: xacc_in = xacc_ff + prod_ext;
               3'd3: yacc_in = prod_ext;
               3'd4: begin
                  yacc_in = yacc_ff - prod_ext;
                  st_in   = G_BOUND;
               end
               default: ;
            endcase
         end
         G_BOUND: st_in = G_CHECK;
         G_CHECK: begin
            if (inside_ok) begin
               st_in = G_DIVX;
            end else begin
               done_in   = 1'b1;
               inside_in = 1'b0;
               chan_in   = '0;
               st_in     = G_IDLE;
            end
         end
         G_DIVX: begin
            if (div_done) begin
               col_in = q_clamp;
               st_in  = G_DIVY;
            end
         end
         G_DIVY: begin
            if (div_done) begin
               chan_in   = chan_full[PAD_W-1:0];
               inside_in = 1'b1;
               done_in   = 1'b1;
               st_in     = G_IDLE;
            end
         end
         default: st_in = G_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= G_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      prod_ff   <= prod_in;
      xacc_ff   <= xacc_in;
      yacc_ff   <= yacc_in;
      xi_ff     <= (st_ff == G_BOUND) ? xi_in : xi_ff;
      yi_ff     <= (st_ff == G_BOUND) ? yi_in : yi_ff;
      col_ff    <= col_in;
      inside_ff <= inside_in;
      chan_ff   <= chan_in;
   end

   assign res.done      = done_ff;
   assign res.in_sector = inside_ff;
   assign res.chan      = chan_ff;

endmodule

>>> design/phl_store.sv
// Pad store: one synchronous memory holding a valid flag and a point index per channel,
// with a clearing sweep after reset and on clear. Depends on phl_pkg.
module phl_store import phl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  phl_store_cmd_type  cmd,
   output phl_store_stat_type stat
);

   logic [POINT_W:0]   mem_ff [NUM_PADS];
   logic [POINT_W:0]   rd_ff, wd;
   logic [PAD_W-1:0]   sweep_addr_ff, sweep_addr_in, wa;
   logic               sweep_ff, sweep_in, done_ff, done_in, we;

   always_comb begin
      we = 1'b0;
      wa = cmd.addr;
      wd = {1'b1, cmd.point};
      if (sweep_ff) begin
         we = 1'b1;
         wa = sweep_addr_ff;
         wd = '0;
      end else if (cmd.go && cmd.kind == KIND_WRITE) begin
         we = 1'b1;
      end
   end

   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      done_in       = 1'b0;
      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + PAD_W'(1);
         if (sweep_addr_ff == '1) begin
            sweep_in = 1'b0;
            done_in  = 1'b1;
         end
      end else if (cmd.go) begin
         case (cmd.kind)
            KIND_CLEAR: begin
               sweep_in      = 1'b1;
               sweep_addr_in = '0;
            end
            KIND_WRITE, KIND_READ: done_in = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      if (cmd.go && cmd.kind == KIND_READ && !sweep_ff) begin
         rd_ff <= mem_ff[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         done_ff       <= 1'b0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         done_ff       <= done_in;
      end
   end

   assign stat.busy  = sweep_ff;
   assign stat.done  = done_ff;
   assign stat.found = rd_ff[POINT_W];
   assign stat.point = rd_ff[POINT_W-1:0];

endmodule

>>> design/pad_hit_locator.sv
// Pad hit locator top: configuration registers, command sequencing, result register.
// Locate: the result strobe follows the geometry, whose column and row indices take two
// divider passes (column, then row); a hit outside ends after the bounds check, undivided.
// Activate inside adds a memory write; lookup a memory read; clear a sweep of the memory.
// busy falls as the strobe rises; next transfer at the edge ending it; no receiver stall.
// Reset restores the register defaults and runs a clearing sweep of every pad entry with busy high.
module pad_hit_locator import phl_pkg::*; #(
   parameter int MAX_SIDE = PHL_MAX_SIDE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_op,
   input  logic [COORD_W-1:0]    req_x_pos,
   input  logic [COORD_W-1:0]    req_y_pos,
   input  logic [POINT_W-1:0]    req_hit_point,
   input  logic [PAD_W-1:0]      req_pad_query,
   output logic                  rsp_valid,
   output logic                  rsp_inside_res,
   output logic [PAD_W-1:0]      rsp_channel,
   output logic                  rsp_found,
   output logic [POINT_W-1:0]    rsp_point_out,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_GEOM  = 2'd1;
   localparam logic [1:0] ST_STORE = 2'd2;

   phl_cfg_type        cfg_ff, cfg_in;
   phl_store_cmd_type  scmd;
   phl_store_stat_type sstat;
   phl_geom_res_type   geom_res;

   logic [1:0]         st_ff, st_in, op_ff, op_in;
   logic [POINT_W-1:0] point_ff, point_in, rsp_point_ff, rsp_point_in;
   logic [PAD_W-1:0]   chan_ff, chan_in, rsp_chan_ff, rsp_chan_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_inside_ff, rsp_inside_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               accept, geom_start;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx)
            REG_CENTER_X: cfg_in.center_x = csr_wdata;
            REG_CENTER_Y: cfg_in.center_y = csr_wdata;
            REG_COS_ROT:  cfg_in.cos_rot  = csr_wdata[TRIG_W-1:0];
            REG_SIN_ROT:  cfg_in.sin_rot  = csr_wdata[TRIG_W-1:0];
            REG_WIDTH_X:  cfg_in.width_x  = csr_wdata[WIDTH_W-1:0];
            REG_WIDTH_Y:  cfg_in.width_y  = csr_wdata[WIDTH_W-1:0];
            REG_COLUMNS:  cfg_in.columns  = csr_wdata[COUNT_W-1:0];
            REG_ROWS:     cfg_in.rows     = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy       = (st_ff != ST_IDLE) || sstat.busy;
   assign accept     = start && !busy;
   assign geom_start = accept && (req_op inside {OP_LOCATE, OP_ACTIVATE});

   phl_geom #(
      .MAX_SIDE (MAX_SIDE)
   ) u_geom (
      .clock (clock),
      .reset (reset),
      .start (geom_start),
      .x_pos (req_x_pos),
      .y_pos (req_y_pos),
      .cfg   (cfg_ff),
      .res   (geom_res)
   );

   phl_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (scmd),
      .stat  (sstat)
   );

   always_comb begin
      st_in         = st_ff;
      op_in         = op_ff;
      point_in      = point_ff;
      chan_in       = chan_ff;
      rsp_valid_in  = 1'b0;
      rsp_inside_in = rsp_inside_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_point_in  = rsp_point_ff;
      scmd.go       = 1'b0;
      scmd.kind     = KIND_READ;
      scmd.addr     = req_pad_query;
      scmd.point    = point_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               point_in = req_hit_point;
               if (req_op inside {OP_LOCATE, OP_ACTIVATE}) begin
                  st_in = ST_GEOM;
               end else begin
                  scmd.go   = 1'b1;
                  scmd.kind = (req_op == OP_LOOKUP) ? KIND_READ : KIND_CLEAR;
                  st_in     = ST_STORE;
               end
            end
         end
         ST_GEOM: begin
            if (geom_res.done) begin
               if (op_ff == OP_ACTIVATE && geom_res.in_sector) begin
                  scmd.go   = 1'b1;
                  scmd.kind = KIND_WRITE;
                  scmd.addr = geom_res.chan;
                  chan_in   = geom_res.chan;
                  st_in     = ST_STORE;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_inside_in = geom_res.in_sector;
                  rsp_chan_in   = geom_res.chan;
                  rsp_found_in  = 1'b0;
                  rsp_point_in  = '0;
                  st_in         = ST_IDLE;
               end
            end
         end
         ST_STORE: begin
            if (sstat.done) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = 1'b0;
               rsp_chan_in   = '0;
               rsp_found_in  = 1'b0;
               rsp_point_in  = '0;
               case (op_ff)
                  OP_ACTIVATE: begin
                     rsp_inside_in = 1'b1;
                     rsp_chan_in   = chan_ff;
                  end
                  OP_LOOKUP: begin
                     rsp_found_in = sstat.found;
                     rsp_point_in = sstat.found ? sstat.point : '0;
                  end
                  default: ;
               endcase
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff            <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         cfg_ff.center_x  <= '0;
         cfg_ff.center_y  <= '0;
         cfg_ff.cos_rot   <= RST_COS_ROT;
         cfg_ff.sin_rot   <= '0;
         cfg_ff.width_x   <= RST_WIDTH;
         cfg_ff.width_y   <= RST_WIDTH;
         cfg_ff.columns   <= RST_COUNT;
         cfg_ff.rows      <= RST_COUNT;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      point_ff      <= point_in;
      chan_ff       <= chan_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_point_ff  <= rsp_point_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_channel    = rsp_chan_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_point_out  = rsp_point_ff;

endmodule

>>> sim/tb_pad_hit_locator.sv
// Self-checking testbench for pad_hit_locator: sector configurations, hit location,
// pad activation, lookup and clear, checked against a cycle-free predictor.
// Depends on phl_pkg and the pad_hit_locator top level only.
module tb_pad_hit_locator;
   import phl_pkg::*;

   typedef struct {
      logic [1:0]         op;
      logic [COORD_W-1:0] x_pos;
      logic [COORD_W-1:0] y_pos;
      logic [POINT_W-1:0] hit_point;
      logic [PAD_W-1:0]   pad_query;
   } hit_cmd_type;

   typedef struct {
      logic               in_sector;
      logic [PAD_W-1:0]   channel;
      logic               found;
      logic [POINT_W-1:0] point;
   } pad_result_type;

   typedef struct {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [TRIG_W-1:0]  cs;
      logic signed [TRIG_W-1:0]  sn;
      logic [WIDTH_W-1:0]        wx;
      logic [WIDTH_W-1:0]        wy;
      logic [COUNT_W-1:0]        nc;
      logic [COUNT_W-1:0]        nr;
   } sector_cfg_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_op = OP_LOCATE;
   logic [COORD_W-1:0]    req_x_pos = '0;
   logic [COORD_W-1:0]    req_y_pos = '0;
   logic [POINT_W-1:0]    req_hit_point = '0;
   logic [PAD_W-1:0]      req_pad_query = '0;
   logic                  rsp_valid;
   logic                  rsp_inside_res;
   logic [PAD_W-1:0]      rsp_channel;
   logic                  rsp_found;
   logic [POINT_W-1:0]    rsp_point_out;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_idx = REG_CENTER_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   hit_cmd_type    pending_cmds[$];
   pad_result_type results_due[$];
   hit_cmd_type    next_cmd;
   pad_result_type want;

   sector_cfg_type       sector;
   logic [NUM_PADS-1:0]  pad_active = '0;
   logic [POINT_W-1:0]   pad_point [NUM_PADS];

   int                   stored_list[$];
   logic [NUM_PADS-1:0]  stored_seen = '0;

   int gap_odds = 0;
   int idle_left = 0;
   int errors = 0;

   pad_hit_locator u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_x_pos      (req_x_pos),
      .req_y_pos      (req_y_pos),
      .req_hit_point  (req_hit_point),
      .req_pad_query  (req_pad_query),
      .rsp_valid      (rsp_valid),
      .rsp_inside_res (rsp_inside_res),
      .rsp_channel    (rsp_channel),
      .rsp_found      (rsp_found),
      .rsp_point_out  (rsp_point_out),
      .csr_we         (csr_we),
      .csr_idx        (csr_idx),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void sector_locate(input logic [COORD_W-1:0] xp,
                                         input logic [COORD_W-1:0] yp,
                                         output logic in_sector,
                                         output logic [PAD_W-1:0] chan);
      logic signed [COORD_W-1:0] xs;
      logic signed [COORD_W-1:0] ys;
      longint dx, dy, c, s, wx, wy, nc, nr, xi, yi, col, row;
      xs = xp;
      ys = yp;
      dx = xs - sector.cx;
      dy = ys - sector.cy;
      c = sector.cs;
      s = sector.sn;
      wx = (sector.wx == 0) ? 1 : sector.wx;
      wy = (sector.wy == 0) ? 1 : sector.wy;
      nc = (sector.nc == 0) ? 1 : ((sector.nc > PHL_MAX_SIDE) ? PHL_MAX_SIDE : sector.nc);
      nr = (sector.nr == 0) ? 1 : ((sector.nr > PHL_MAX_SIDE) ? PHL_MAX_SIDE : sector.nr);
      xi = ((dx * c + dy * s) >>> Q_SHIFT) + (wx >>> 1);
      yi = ((dy * c - dx * s) >>> Q_SHIFT) + (wy >>> 1);
      in_sector = !(xi < 0 || xi > wx || yi < 0 || yi > wy);
      chan = '0;
      if (in_sector) begin
         col = (xi * nc) / wx;
         row = (yi * nr) / wy;
         if (col >= nc) col = nc - 1;
         if (row >= nr) row = nr - 1;
         chan = PAD_W'(row * nc + col);
      end
   endfunction

   function automatic logic [COORD_W-1:0] clip24(input longint v);
      if (v > 8388607) return 24'h7FFFFF;
      if (v < -8388608) return 24'h800000;
      return COORD_W'(v);
   endfunction

   function automatic longint pick_offset(input longint w);
      int k;
      longint v;
      k = $urandom_range(0, 9);
      case (k)
         0: v = 0;
         1: v = w;
         2: v = -1;
         3: v = w + 1;
         default: v = longint'($urandom_range(0, w + w / 4 + 4)) - (w / 8 + 2);
      endcase
      return v - w / 2;
   endfunction

   task automatic check_field(input string name, input logic [POINT_W-1:0] exp_v,
                              input logic [POINT_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected 0x%0h actual 0x%0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   task automatic queue_cmd(input logic [1:0] op, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [POINT_W-1:0] pt,
                            input logic [PAD_W-1:0] pad);
      hit_cmd_type cmd;
      logic ins;
      logic [PAD_W-1:0] ch;
      cmd = '{op: op, x_pos: x, y_pos: y, hit_point: pt, pad_query: pad};
      pending_cmds = {pending_cmds, cmd};
      if (op == OP_ACTIVATE) begin
         sector_locate(x, y, ins, ch);
         if (ins && !stored_seen[ch]) begin
            stored_seen[ch] = 1'b1;
            stored_list = {stored_list, int'(ch)};
         end
      end
   endtask

   task automatic queue_random_cmd();
      int roll;
      longint w, h, lx, ly;
      logic [COORD_W-1:0] gx, gy;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         queue_cmd(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom), POINT_W'($urandom),
                   PAD_W'($urandom));
      end else if (roll >= 70 && stored_list.size() != 0) begin
         queue_cmd(OP_LOOKUP, COORD_W'($urandom), COORD_W'($urandom), POINT_W'($urandom),
                   PAD_W'(stored_list[$urandom_range(0, stored_list.size() - 1)]));
      end else begin
         if ($urandom_range(0, 9) == 0) begin
            gx = COORD_W'($urandom);
            gy = COORD_W'($urandom);
         end else begin
            w = (sector.wx == 0) ? 1 : sector.wx;
            h = (sector.wy == 0) ? 1 : sector.wy;
            lx = pick_offset(w);
            ly = pick_offset(h);
            gx = clip24(sector.cx + ((lx * sector.cs - ly * sector.sn) >>> Q_SHIFT));
            gy = clip24(sector.cy + ((lx * sector.sn + ly * sector.cs) >>> Q_SHIFT));
         end
         queue_cmd((roll < 36) ? OP_LOCATE : OP_ACTIVATE, gx, gy,
                   ($urandom_range(0, 7) == 0) ? 31'h7FFFFFFF : POINT_W'($urandom),
                   PAD_W'($urandom));
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (reset || busy || start || pending_cmds.size() != 0 || results_due.size() != 0);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   task automatic program_sector(input sector_cfg_type s);
      wait_idle();
      @(posedge clock);
      put_reg(REG_CENTER_X, CSR_DATA_W'(s.cx));
      put_reg(REG_CENTER_Y, CSR_DATA_W'(s.cy));
      put_reg(REG_COS_ROT, CSR_DATA_W'($unsigned(s.cs)));
      put_reg(REG_SIN_ROT, CSR_DATA_W'($unsigned(s.sn)));
      put_reg(REG_WIDTH_X, CSR_DATA_W'(s.wx));
      put_reg(REG_WIDTH_Y, CSR_DATA_W'(s.wy));
      put_reg(REG_COLUMNS, CSR_DATA_W'(s.nc));
      put_reg(REG_ROWS, CSR_DATA_W'(s.nr));
      csr_we <= 1'b0;
   endtask

   // hold the presented command while busy; insert idle bursts after a transfer
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else if (!(start && busy)) begin
         if (start && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            idle_left = $urandom_range(1, 8);
         if (idle_left > 0) begin
            if (!busy) idle_left--;
            start <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            next_cmd = pending_cmds.pop_front();
            req_op <= next_cmd.op;
            req_x_pos <= next_cmd.x_pos;
            req_y_pos <= next_cmd.y_pos;
            req_hit_point <= next_cmd.hit_point;
            req_pad_query <= next_cmd.pad_query;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         sector = '{cx: 0, cy: 0, cs: RST_COS_ROT, sn: 0, wx: RST_WIDTH, wy: RST_WIDTH,
                    nc: RST_COUNT, nr: RST_COUNT};
         pad_active = '0;
         results_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_idx)
               REG_CENTER_X: sector.cx = csr_wdata;
               REG_CENTER_Y: sector.cy = csr_wdata;
               REG_COS_ROT:  sector.cs = csr_wdata[TRIG_W-1:0];
               REG_SIN_ROT:  sector.sn = csr_wdata[TRIG_W-1:0];
               REG_WIDTH_X:  sector.wx = csr_wdata[WIDTH_W-1:0];
               REG_WIDTH_Y:  sector.wy = csr_wdata[WIDTH_W-1:0];
               REG_COLUMNS:  sector.nc = csr_wdata[COUNT_W-1:0];
               REG_ROWS:     sector.nr = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (results_due.size() == 0) begin
               $error("result strobe with no command outstanding: channel 0x%0h", rsp_channel);
               errors++;
            end else begin
               want = results_due.pop_front();
               check_field("inside_res", want.in_sector, rsp_inside_res);
               check_field("channel", want.channel, rsp_channel);
               check_field("found", want.found, rsp_found);
               check_field("point_out", want.point, rsp_point_out);
            end
         end
         if (start && !busy) begin
            want = '{in_sector: 1'b0, channel: '0, found: 1'b0, point: '0};
            case (req_op)
               OP_LOCATE, OP_ACTIVATE: begin
                  sector_locate(req_x_pos, req_y_pos, want.in_sector, want.channel);
                  if (want.in_sector && req_op == OP_ACTIVATE) begin
                     pad_point[want.channel] = req_hit_point;
                     pad_active[want.channel] = 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  if (pad_active[req_pad_query]) begin
                     want.found = 1'b1;
                     want.point = pad_point[req_pad_query];
                  end
               end
               default: pad_active = '0;
            endcase
            results_due = {results_due, want};
         end
      end
   end

   initial begin
      sector_cfg_type plan [9];
      int gap_plan [9];
      int p;
      logic ins;
      logic [PAD_W-1:0] ch;
      gap_plan = '{3, 0, 4, 2, 0, 3, 5, 3, 0};
      plan[0] = '{cx: 1000, cy: -2000, cs: -32768, sn: 0, wx: 6400, wy: 3200, nc: 64, nr: 64};
      plan[1] = '{cx: 0, cy: 0, cs: 32767, sn: 0, wx: 25600, wy: 25600, nc: 1, nr: 1};
      plan[2] = '{cx: -5000, cy: 7000, cs: 0, sn: -32768, wx: 10000, wy: 3000, nc: 7, nr: 13};
      plan[3] = '{cx: 123456, cy: -654321, cs: 28378, sn: 16384, wx: 40000, wy: 20000,
                  nc: 64, nr: 64};
      plan[4] = '{cx: 0, cy: 0, cs: 32767, sn: 0, wx: 0, wy: 0, nc: 0, nr: 0};
      plan[5] = '{cx: -8388608, cy: 8388607, cs: -32768, sn: 32767, wx: 8388607,
                  wy: 8388607, nc: 127, nr: 100};
      plan[6] = '{cx: 8388607, cy: -8388608, cs: 32767, sn: 32767, wx: 1, wy: 2, nc: 64, nr: 2};
      for (p = 7; p < 9; p++) begin
         plan[p] = '{cx: COORD_W'($urandom), cy: COORD_W'($urandom),
                     cs: TRIG_W'($urandom), sn: TRIG_W'($urandom),
                     wx: WIDTH_W'($urandom_range(64, 300000)),
                     wy: WIDTH_W'($urandom_range(64, 300000)),
                     nc: COUNT_W'($urandom_range(1, 64)), nr: COUNT_W'($urandom_range(1, 64))};
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (reset || !busy);
      for (p = 0; p < 9; p++) begin
         gap_odds = gap_plan[p];
         program_sector(plan[p]);
         @(negedge clock);
         if (p == 0) begin
            queue_cmd(OP_LOCATE, 4200, -400, 0, 0);
            queue_cmd(OP_LOCATE, -2200, -3600, 0, 0);
            queue_cmd(OP_LOCATE, 4201, -400, 0, 0);
            queue_cmd(OP_LOCATE, -2200, -3601, 0, 0);
            queue_cmd(OP_ACTIVATE, 4200, -400, 31'h0, 12'hFFF);
            queue_cmd(OP_ACTIVATE, -2200, -3600, 31'h7FFFFFFF, 12'hFFF);
            queue_cmd(OP_ACTIVATE, 4200, -400, 31'h2AAAAAAA, 0);
            queue_cmd(OP_LOOKUP, 0, 0, 0, 0);
            queue_cmd(OP_LOOKUP, 0, 0, 0, 12'hFFF);
            queue_cmd(OP_ACTIVATE, 4201, -400, 31'h5, 0);
            queue_cmd(OP_ACTIVATE, 1000, -2000, 31'h55555555, 0);
            sector_locate(1000, -2000, ins, ch);
            queue_cmd(OP_LOOKUP, 0, 0, 0, ch);
            queue_cmd(OP_LOCATE, 24'h800000, 24'h800000, 31'h7FFFFFFF, 12'hFFF);
            queue_cmd(OP_LOCATE, 24'h7FFFFF, 24'h7FFFFF, 0, 0);
            queue_cmd(OP_ACTIVATE, 24'h7FFFFF, 24'h800000, 31'h1234567, 0);
            queue_cmd(OP_CLEAR, 0, 0, 0, 0);
            queue_cmd(OP_LOOKUP, 0, 0, 0, 0);
            queue_cmd(OP_LOOKUP, 0, 0, 0, 12'hFFF);
            queue_cmd(OP_LOOKUP, 0, 0, 0, ch);
         end
         repeat (200) queue_random_cmd();
      end
      wait_idle();
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
